/* design/legik_pkg.sv */
// Shared types, constants and step functions for the leg inverse kinematics block.
// Used by legik_cordic and leg_inverse_kinematics; depends on nothing else.
package legik_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int LEN_W   = 20;
    localparam int ANG_W   = 20;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COXA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEMUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIBIA = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0] COXA_RESET  = 20'd3277;
    localparam logic [LEN_W-1:0] FEMUR_RESET = 20'd6554;
    localparam logic [LEN_W-1:0] TIBIA_RESET = 20'd6554;

    typedef logic signed [ANG_W-1:0] angle_t;

    // Angle constants, radians in Q16
    localparam angle_t PI_Q16  = 20'sd205887;
    localparam angle_t PI3_Q16 = 20'sd68629;

    // CORDIC setup
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int CORDIC_MAX_STEPS = 32;
    localparam int OPND_W   = 27;
    localparam int SCALE_SH = 20;
    localparam int CORDIC_W = 50;
    localparam int TAB_W    = 16;

    // atan(2^-i) in Q16, rounded to nearest
    localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,
        16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0,
        16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
    };

    // Payload words
    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } in_word_t;

    typedef struct packed {
        angle_t hip_angle;
        angle_t thigh_angle;
        angle_t shin_angle;
        logic   out_of_reach;
    } out_word_t;

    // Digit-by-digit square root, one result bit per step
    localparam int ROOT_W = 25;
    localparam int REM_W  = ROOT_W + 4;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        sqrt_acc_t        r;
        rem_sh = {a.rem[REM_W-3:0], pair};
        trial  = {2'b00, a.root, 2'b01};
        if (rem_sh >= trial) begin
            r.rem  = rem_sh - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            r.rem  = rem_sh;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Restoring division, one quotient bit per step
    localparam int DIV_W = 48;
    localparam int QUO_W = 16;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_acc_t;

    function automatic div_acc_t div_step(div_acc_t a, logic [DIV_W-1:0] den);
        logic [DIV_W-1:0] sh;
        div_acc_t         r;
        sh = {a.rem[DIV_W-2:0], 1'b0};
        if (sh >= den) begin
            r.rem = sh - den;
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end
        else begin
            r.rem = sh;
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* design/leg_inverse_kinematics.sv */
// Three-joint leg inverse kinematics: foot target in, coxa/femur/tibia angles out.
// Depends on legik_pkg and legik_cordic.
//
// The block takes one target word per clock unless the output is stalled, and returns
// one angle word per target, in order. The pipeline holds three digit-by-digit
// square-root chains (24, 25 and 17 stages), a 16-stage divider for the two cosines, and
// four CORDIC atan2 units of CORDIC_STEPS + 1 stages running side by side. A stall on
// the output freezes the whole pipe; the output register keeps its word until it is
// taken. Length registers must be written only while no target is in flight.
module leg_inverse_kinematics #(
    parameter int CORDIC_STEPS = legik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  legik_pkg::in_word_t                    in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output legik_pkg::out_word_t                   out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [legik_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [legik_pkg::LEN_W-1:0]            cfg_data
);

    localparam int R_STEPS   = 24;
    localparam int L_STEPS   = 25;
    localparam int C_STEPS   = 17;
    localparam int DIV_STEPS = legik_pkg::QUO_W;
    localparam int FRONT_LAT = 3 + R_STEPS + 3 + L_STEPS + 2 + DIV_STEPS + 2 + C_STEPS;
    localparam int LAT       = FRONT_LAT + CORDIC_STEPS + 2;
    localparam int DW        = legik_pkg::DIV_W;
    localparam int NUM_W     = 52;
    localparam int OW        = legik_pkg::OPND_W;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } xyz_t;

    typedef struct packed {
        xyz_t               pos;
        logic signed [25:0] d;
        logic [49:0]        l2;
        logic [39:0]        ff;
        logic [39:0]        tt;
        logic               zero;
    } mid_t;

    typedef struct packed {
        xyz_t               pos;
        logic signed [25:0] d;
        logic               zero;
        logic               flag;
    } tail_t;

    typedef struct packed {
        logic          sat;
        logic          neg;
        logic [DW-1:0] den;
    } div_side_t;

    typedef struct packed {
        logic zero;
        logic flag;
    } fl_t;

    logic en;
    logic [LAT-1:0] vld_reg;

    logic [legik_pkg::LEN_W-1:0] coxa_reg;
    logic [legik_pkg::LEN_W-1:0] femur_reg;
    logic [legik_pkg::LEN_W-1:0] tibia_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_reg  <= legik_pkg::COXA_RESET;
            femur_reg <= legik_pkg::FEMUR_RESET;
            tibia_reg <= legik_pkg::TIBIA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                legik_pkg::CFG_COXA:  coxa_reg  <= cfg_data;
                legik_pkg::CFG_FEMUR: femur_reg <= cfg_data;
                legik_pkg::CFG_TIBIA: tibia_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless the output word is held
    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Input register, squares of x and y, their sum
    xyz_t               in_pos_reg;
    xyz_t               sq_pos_reg;
    logic [46:0]        sq_xx_reg;
    logic [46:0]        sq_yy_reg;
    xyz_t               sm_pos_reg;
    logic [47:0]        sm_sum_reg;
    logic signed [47:0] xx_full;
    logic signed [47:0] yy_full;

    assign xx_full = in_pos_reg.x * in_pos_reg.x;
    assign yy_full = in_pos_reg.y * in_pos_reg.y;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_pos_reg.x <= in_data.target_x;
            in_pos_reg.y <= in_data.target_y;
            in_pos_reg.z <= in_data.target_z;
            sq_pos_reg   <= in_pos_reg;
            sq_xx_reg    <= xx_full[46:0];
            sq_yy_reg    <= yy_full[46:0];
            sm_pos_reg   <= sq_pos_reg;
            sm_sum_reg   <= {1'b0, sq_xx_reg} + {1'b0, sq_yy_reg};
        end
    end

    // Root of x^2 + y^2
    xyz_t                  rq_pos_reg [R_STEPS];
    legik_pkg::sqrt_acc_t  rq_acc_reg [R_STEPS];
    logic [47:0]           rq_rad_reg [R_STEPS];

    for (genvar i = 0; i < R_STEPS; i++)
    begin : g_rsqrt
        xyz_t                 pos_in;
        legik_pkg::sqrt_acc_t acc_in;
        logic [47:0]          rad_in;

        if (i == 0)
        begin : g_first
            assign pos_in = sm_pos_reg;
            assign acc_in = '0;
            assign rad_in = sm_sum_reg;
        end
        else
        begin : g_rest
            assign pos_in = rq_pos_reg[i-1];
            assign acc_in = rq_acc_reg[i-1];
            assign rad_in = rq_rad_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rq_pos_reg[i] <= pos_in;
                rq_acc_reg[i] <= legik_pkg::sqrt_step(acc_in, rad_in[47:46]);
                rq_rad_reg[i] <= {rad_in[45:0], 2'b00};
            end
        end
    end

    // Horizontal reach past the coxa, its square with z^2, and the length squares
    xyz_t               dd_pos_reg;
    logic signed [25:0] dd_d_reg;
    xyz_t               m2_pos_reg;
    logic signed [25:0] m2_d_reg;
    logic [48:0]        m2_dd_reg;
    logic [46:0]        m2_zz_reg;
    logic [39:0]        m2_ff_reg;
    logic [39:0]        m2_tt_reg;
    mid_t               l2_mid_reg;
    logic [23:0]        r_root;
    logic signed [51:0] dsq_full;
    logic signed [47:0] zsq_full;
    logic [49:0]        l2_sum;

    assign r_root   = rq_acc_reg[R_STEPS-1].root[23:0];
    assign dsq_full = dd_d_reg * dd_d_reg;
    assign zsq_full = dd_pos_reg.z * dd_pos_reg.z;
    assign l2_sum   = {1'b0, m2_dd_reg} + {3'b000, m2_zz_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_pos_reg      <= rq_pos_reg[R_STEPS-1];
            dd_d_reg        <= $signed({2'b00, r_root}) - $signed({6'b000000, coxa_reg});
            m2_pos_reg      <= dd_pos_reg;
            m2_d_reg        <= dd_d_reg;
            m2_dd_reg       <= dsq_full[48:0];
            m2_zz_reg       <= zsq_full[46:0];
            m2_ff_reg       <= femur_reg * femur_reg;
            m2_tt_reg       <= tibia_reg * tibia_reg;
            l2_mid_reg.pos  <= m2_pos_reg;
            l2_mid_reg.d    <= m2_d_reg;
            l2_mid_reg.l2   <= l2_sum;
            l2_mid_reg.ff   <= m2_ff_reg;
            l2_mid_reg.tt   <= m2_tt_reg;
            l2_mid_reg.zero <= (l2_sum == '0);
        end
    end

    // Root of L^2
    mid_t                  lq_mid_reg [L_STEPS];
    legik_pkg::sqrt_acc_t  lq_acc_reg [L_STEPS];
    logic [49:0]           lq_rad_reg [L_STEPS];

    for (genvar i = 0; i < L_STEPS; i++)
    begin : g_lsqrt
        mid_t                 mid_in;
        legik_pkg::sqrt_acc_t acc_in;
        logic [49:0]          rad_in;

        if (i == 0)
        begin : g_first
            assign mid_in = l2_mid_reg;
            assign acc_in = '0;
            assign rad_in = l2_mid_reg.l2;
        end
        else
        begin : g_rest
            assign mid_in = lq_mid_reg[i-1];
            assign acc_in = lq_acc_reg[i-1];
            assign rad_in = lq_rad_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_mid_reg[i] <= mid_in;
                lq_acc_reg[i] <= legik_pkg::sqrt_step(acc_in, rad_in[49:48]);
                lq_rad_reg[i] <= {rad_in[47:0], 2'b00};
            end
        end
    end

    // Cosine numerators and denominators (lane 0 femur, lane 1 tibia)
    mid_t                     lq_last;
    logic [24:0]              l_root;
    logic [44:0]              lf_prod;
    logic [44:0]              lt_prod;
    tail_t                    nm_tail_reg;
    logic signed [NUM_W-1:0]  nm_num_reg [2];
    logic [45:0]              nm_den_reg [2];

    assign lq_last = lq_mid_reg[L_STEPS-1];
    assign l_root  = lq_acc_reg[L_STEPS-1].root;
    assign lf_prod = l_root * femur_reg;
    assign lt_prod = l_root * tibia_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_tail_reg.pos  <= lq_last.pos;
            nm_tail_reg.d    <= lq_last.d;
            nm_tail_reg.zero <= lq_last.zero;
            nm_tail_reg.flag <= lq_last.zero;
            nm_num_reg[0]    <= $signed({12'd0, lq_last.ff}) + $signed({2'b00, lq_last.l2})
                                - $signed({12'd0, lq_last.tt});
            nm_num_reg[1]    <= $signed({2'b00, lq_last.l2}) + $signed({12'd0, lq_last.tt})
                                - $signed({12'd0, lq_last.ff});
            nm_den_reg[0]    <= {lf_prod, 1'b0};
            nm_den_reg[1]    <= {lt_prod, 1'b0};
        end
    end

    // Clip the ratio to [-1, 1] and set up the divider
    tail_t                 cl_tail_reg;
    div_side_t             cl_side_reg [2];
    logic [DW-1:0]         cl_mag_reg  [2];
    logic [1:0]            clip;

    for (genvar k = 0; k < 2; k++)
    begin : g_clip
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] dens;
        logic signed [NUM_W-1:0] mag;
        logic                    ge;
        logic                    le;

        assign num  = nm_num_reg[k];
        assign dens = $signed({{(NUM_W-46){1'b0}}, nm_den_reg[k]});
        assign mag  = num[NUM_W-1] ? -num : num;
        assign ge   = (num >= dens);
        assign le   = (num <= -dens);
        assign clip[k] = ge ? (num != dens) : (le && (num != -dens));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cl_side_reg[k].sat <= ge || le;
                cl_side_reg[k].neg <= ge ? 1'b0 : (le ? 1'b1 : num[NUM_W-1]);
                cl_side_reg[k].den <= {{(DW-46){1'b0}}, nm_den_reg[k]};
                cl_mag_reg[k]      <= mag[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_tail_reg      <= nm_tail_reg;
            cl_tail_reg.flag <= nm_tail_reg.flag || clip[0] || clip[1];
        end
    end

    // Divide |num| * 2^16 by den, one quotient bit per stage
    tail_t                dv_tail_reg [DIV_STEPS];
    div_side_t            dv_side_reg [DIV_STEPS][2];
    legik_pkg::div_acc_t  dv_acc_reg  [DIV_STEPS][2];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        tail_t tail_in;

        if (i == 0)
        begin : g_first
            assign tail_in = cl_tail_reg;
        end
        else
        begin : g_rest
            assign tail_in = dv_tail_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_tail_reg[i] <= tail_in;
            end
        end

        for (genvar k = 0; k < 2; k++)
        begin : g_lane
            div_side_t           side_in;
            legik_pkg::div_acc_t acc_in;

            if (i == 0)
            begin : g_first
                assign side_in = cl_side_reg[k];
                assign acc_in  = '{rem: cl_mag_reg[k], quo: '0};
            end
            else
            begin : g_rest
                assign side_in = dv_side_reg[i-1][k];
                assign acc_in  = dv_acc_reg[i-1][k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_side_reg[i][k] <= side_in;
                    dv_acc_reg[i][k]  <= legik_pkg::div_step(acc_in, side_in.den);
                end
            end
        end
    end

    // Signed Q16 cosine, then 2^32 - c^2 for the sine root
    tail_t              cc_tail_reg;
    logic signed [17:0] cc_c_reg [2];
    tail_t              cs_tail_reg;
    logic signed [17:0] cs_c_reg [2];
    logic [33:0]        cs_rad_reg [2];

    for (genvar k = 0; k < 2; k++)
    begin : g_cos
        div_side_t          side;
        logic signed [17:0] q;
        logic signed [35:0] csq;

        assign side = dv_side_reg[DIV_STEPS-1][k];
        assign q    = $signed({2'b00, dv_acc_reg[DIV_STEPS-1][k].quo});
        assign csq  = cc_c_reg[k] * cc_c_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (side.sat)
                begin
                    cc_c_reg[k] <= side.neg ? -18'sd65536 : 18'sd65536;
                end
                else
                begin
                    cc_c_reg[k] <= side.neg ? -q : q;
                end
                cs_c_reg[k]   <= cc_c_reg[k];
                cs_rad_reg[k] <= 34'h1_0000_0000 - csq[33:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_tail_reg <= dv_tail_reg[DIV_STEPS-1];
            cs_tail_reg <= cc_tail_reg;
        end
    end

    // Sine roots for the two acos terms
    tail_t                 cq_tail_reg [C_STEPS];
    logic signed [17:0]    cq_c_reg    [C_STEPS][2];
    legik_pkg::sqrt_acc_t  cq_acc_reg  [C_STEPS][2];
    logic [33:0]           cq_rad_reg  [C_STEPS][2];

    for (genvar i = 0; i < C_STEPS; i++)
    begin : g_csqrt
        tail_t tail_in;

        if (i == 0)
        begin : g_first
            assign tail_in = cs_tail_reg;
        end
        else
        begin : g_rest
            assign tail_in = cq_tail_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cq_tail_reg[i] <= tail_in;
            end
        end

        for (genvar k = 0; k < 2; k++)
        begin : g_lane
            logic signed [17:0]   c_in;
            legik_pkg::sqrt_acc_t acc_in;
            logic [33:0]          rad_in;

            if (i == 0)
            begin : g_first
                assign c_in   = cs_c_reg[k];
                assign acc_in = '0;
                assign rad_in = cs_rad_reg[k];
            end
            else
            begin : g_rest
                assign c_in   = cq_c_reg[i-1][k];
                assign acc_in = cq_acc_reg[i-1][k];
                assign rad_in = cq_rad_reg[i-1][k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cq_c_reg[i][k]   <= c_in;
                    cq_acc_reg[i][k] <= legik_pkg::sqrt_step(acc_in, rad_in[33:32]);
                    cq_rad_reg[i][k] <= {rad_in[31:0], 2'b00};
                end
            end
        end
    end

    // Four atan2 units side by side
    tail_t                 cq_last;
    logic signed [OW-1:0]  op_y [4];
    logic signed [OW-1:0]  op_x [4];
    legik_pkg::angle_t     ang  [4];

    assign cq_last = cq_tail_reg[C_STEPS-1];
    assign op_y[0] = {{(OW-24){cq_last.pos.y[23]}}, cq_last.pos.y};
    assign op_x[0] = {{(OW-24){cq_last.pos.x[23]}}, cq_last.pos.x};
    assign op_y[1] = {{(OW-24){cq_last.pos.z[23]}}, cq_last.pos.z};
    assign op_x[1] = {{(OW-26){cq_last.d[25]}}, cq_last.d};

    for (genvar k = 0; k < 2; k++)
    begin : g_acos_op
        assign op_y[k+2] = {{(OW-17){1'b0}}, cq_acc_reg[C_STEPS-1][k].root[16:0]};
        assign op_x[k+2] = {{(OW-18){cq_c_reg[C_STEPS-1][k][17]}}, cq_c_reg[C_STEPS-1][k]};
    end

    for (genvar u = 0; u < 4; u++)
    begin : g_atan
        legik_cordic #(
            .STEPS (CORDIC_STEPS)
        ) u_cordic (
            .clk  (clk),
            .en   (en),
            .y_in (op_y[u]),
            .x_in (op_x[u]),
            .ang  (ang[u])
        );
    end

    // Carry the flags alongside the CORDIC stages
    fl_t fl_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg[0].zero <= cq_last.zero;
            fl_reg[0].flag <= cq_last.flag;
            for (int j = 1; j <= CORDIC_STEPS; j++)
            begin
                fl_reg[j] <= fl_reg[j-1];
            end
        end
    end

    // Combine the joint angles into the output word
    legik_pkg::out_word_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.out_of_reach <= fl_reg[CORDIC_STEPS].flag;
            if (fl_reg[CORDIC_STEPS].zero)
            begin
                out_reg.hip_angle   <= '0;
                out_reg.thigh_angle <= '0;
                out_reg.shin_angle  <= '0;
            end
            else
            begin
                out_reg.hip_angle   <= ang[0];
                out_reg.thigh_angle <= ang[2] - ang[1];
                out_reg.shin_angle  <= ang[2] + ang[3] - legik_pkg::PI3_Q16;
            end
        end
    end

    assign out_data = out_reg;

endmodule

/* design/legik_cordic.sv */
// Pipelined atan2 in Q16: one fold stage, then one vectoring iteration per stage.
// Depends on legik_pkg.
module legik_cordic #(
    parameter int STEPS = legik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [legik_pkg::OPND_W-1:0]      y_in,
    input  logic signed [legik_pkg::OPND_W-1:0]      x_in,
    output legik_pkg::angle_t                        ang
);

    localparam int CW = legik_pkg::CORDIC_W;
    localparam int SH = legik_pkg::SCALE_SH;
    localparam int OW = legik_pkg::OPND_W;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        legik_pkg::angle_t    ang;
        logic                 hold;
    } rot_t;

    rot_t                 pre_next;
    rot_t                 stg_reg [STEPS+1];
    logic signed [CW-1:0] xw;
    logic signed [CW-1:0] yw;

    // Scale operands by 2^20
    assign xw = {{(CW-OW-SH){x_in[OW-1]}}, x_in, {SH{1'b0}}};
    assign yw = {{(CW-OW-SH){y_in[OW-1]}}, y_in, {SH{1'b0}}};

    // Fold the left half plane; a zero y fixes the angle outright
    always_comb
    begin
        pre_next.hold = (y_in == '0);
        pre_next.x    = xw;
        pre_next.y    = yw;
        pre_next.ang  = '0;
        if (y_in == '0)
        begin
            pre_next.ang = x_in[OW-1] ? legik_pkg::PI_Q16 : '0;
        end
        else if (x_in[OW-1])
        begin
            pre_next.ang = y_in[OW-1] ? -legik_pkg::PI_Q16 : legik_pkg::PI_Q16;
            pre_next.x   = -xw;
            pre_next.y   = -yw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0] <= pre_next;
        end
    end

    // Rotate toward the x axis, one step per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        rot_t                 cur;
        rot_t                 nxt;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        legik_pkg::angle_t    step_ang;

        assign cur      = stg_reg[i];
        assign xs       = cur.x >>> i;
        assign ys       = cur.y >>> i;
        assign step_ang = legik_pkg::angle_t'({4'b0000, legik_pkg::ATAN_TAB[i]});

        always_comb
        begin
            nxt = cur;
            if (!cur.hold)
            begin
                if (!cur.y[CW-1])
                begin
                    nxt.x   = cur.x + ys;
                    nxt.y   = cur.y - xs;
                    nxt.ang = cur.ang + step_ang;
                end
                else
                begin
                    nxt.x   = cur.x - ys;
                    nxt.y   = cur.y + xs;
                    nxt.ang = cur.ang - step_ang;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[i+1] <= nxt;
            end
        end
    end

    assign ang = stg_reg[STEPS].ang;

endmodule
